@@ hw/rtl/gffc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gffc_pkg;

  localparam int unsigned IDX_W   = 10;
  localparam int unsigned COLOR_W = 8;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [COLOR_W-1:0] color_t;

  typedef struct packed {
    logic   colored;
    color_t color;
  } store_entry_t;

  localparam store_entry_t UNCOLORED = '{colored: 1'b0, color: '0};

endpackage

`default_nettype wire

@@ hw/rtl/gffc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface gffc_in_if;
  logic           valid;
  logic           ready;
  gffc_pkg::idx_t vertex_index;
  gffc_pkg::idx_t neighbor_index;
  logic           has_neighbor;
  logic           last_neighbor;

  modport source (output valid, output vertex_index, output neighbor_index,
                  output has_neighbor, output last_neighbor, input ready);
  modport sink   (input valid, input vertex_index, input neighbor_index,
                  input has_neighbor, input last_neighbor, output ready);
endinterface

interface gffc_out_if;
  logic             valid;
  logic             ready;
  gffc_pkg::idx_t   colored_vertex;
  gffc_pkg::color_t chosen_color;
  logic             color_found;

  modport source (output valid, output colored_vertex, output chosen_color,
                  output color_found, input ready);
  modport sink   (input valid, input colored_vertex, input chosen_color,
                  input color_found, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/greedy_first_fit_vertex_coloring.sv @@
`timescale 1ns / 1ps
`default_nettype none

// a final neighbor beat waits in s1 while a result is pending and out_ch.ready is low
// throughput: one input beat per cycle while no final beat stalls, set by the single
// color store read port, the write of the previous vertex forwarded into the next read
// reset: a clearing pass writes every color store entry to uncolored, one per cycle,
// and no input beat is taken until it ends; the used map clears at once

module greedy_first_fit_vertex_coloring #(
  parameter int unsigned NUM_VERTICES = 1024,
  parameter int unsigned NUM_COLORS   = 256
) (
  input  wire         clk,
  input  wire         rst_n,
  gffc_in_if.sink     in_ch,
  gffc_out_if.source  out_ch
);

  localparam int unsigned AW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
  localparam int unsigned CW = (NUM_COLORS > 1) ? $clog2(NUM_COLORS) : 1;
  localparam int unsigned IW = gffc_pkg::IDX_W;

  gffc_pkg::store_entry_t store_mem [NUM_VERTICES];

  logic                   init_done_r;
  logic [AW-1:0]          clr_addr_r;

  logic                   s1_valid_r;
  logic                   s1_hit_r;
  logic                   s1_last_r;
  logic                   s1_vtx_ok_r;
  gffc_pkg::idx_t         s1_vtx_r;
  logic [AW-1:0]          s1_vtx_addr_r;
  gffc_pkg::store_entry_t rd_data_r;
  logic                   fwd_valid_r;
  gffc_pkg::store_entry_t fwd_data_r;

  logic [NUM_COLORS-1:0]  map_r;
  logic [NUM_COLORS-1:0]  map_set;
  logic [NUM_COLORS-1:0]  map_nxt;

  logic                   out_valid_r;
  gffc_pkg::idx_t         out_vtx_r;
  gffc_pkg::color_t       out_color_r;
  logic                   out_found_r;

  logic                   accept;
  logic                   s1_go;
  logic                   s1_adv;
  logic                   s1_fin;
  logic [AW-1:0]          rd_addr;
  logic [IW+AW-1:0]       nbr_ext;
  logic [IW+AW-1:0]       vtx_ext;
  logic                   in_hit;
  logic                   in_vtx_ok;
  gffc_pkg::store_entry_t nbr_entry;
  logic                   color_in_range;
  gffc_pkg::color_t       pick;
  logic                   found;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  gffc_pkg::store_entry_t wr_data;

  // handshake and advance
  assign s1_go   = !s1_last_r || !out_valid_r || out_ch.ready;
  assign s1_adv  = s1_valid_r && s1_go;
  assign s1_fin  = s1_adv && s1_last_r;
  assign in_ch.ready = init_done_r && (!s1_valid_r || s1_go);
  assign accept  = in_ch.valid && in_ch.ready;

  assign nbr_ext   = {{AW{1'b0}}, in_ch.neighbor_index};
  assign vtx_ext   = {{AW{1'b0}}, in_ch.vertex_index};
  assign rd_addr   = nbr_ext[AW-1:0];
  assign in_hit    = in_ch.has_neighbor && (32'(in_ch.neighbor_index) < NUM_VERTICES);
  assign in_vtx_ok = 32'(in_ch.vertex_index) < NUM_VERTICES;

  // used map update and first fit
  assign nbr_entry      = fwd_valid_r ? fwd_data_r : rd_data_r;
  assign color_in_range = 32'(nbr_entry.color) < NUM_COLORS;

  always_comb begin
    map_set = map_r;
    if (s1_hit_r && nbr_entry.colored && color_in_range) begin
      map_set[nbr_entry.color[CW-1:0]] = 1'b1;
    end
  end

  always_comb begin
    pick  = '0;
    found = 1'b0;
    for (int i = NUM_COLORS - 1; i >= 0; i--) begin
      if (!map_set[i]) begin
        pick  = gffc_pkg::COLOR_W'(i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    map_nxt = map_r;
    if (s1_adv) begin
      map_nxt = s1_last_r ? '0 : map_set;
    end
  end

  // store write port shared by the clearing pass and the final beats
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s1_vtx_addr_r;
    wr_data = gffc_pkg::UNCOLORED;
    if (!init_done_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
    end else if (s1_fin && s1_vtx_ok_r) begin
      wr_en = 1'b1;
      if (found) begin
        wr_data.colored = 1'b1;
        wr_data.color   = pick;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (accept) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hit_r      <= in_hit;
      s1_last_r     <= in_ch.last_neighbor;
      s1_vtx_ok_r   <= in_vtx_ok;
      s1_vtx_r      <= in_ch.vertex_index;
      s1_vtx_addr_r <= vtx_ext[AW-1:0];
      fwd_valid_r   <= wr_en && (wr_addr == rd_addr);
      fwd_data_r    <= wr_data;
    end
    if (s1_fin) begin
      out_vtx_r   <= s1_vtx_r;
      out_color_r <= found ? pick : '0;
      out_found_r <= found;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_done_r <= 1'b0;
      clr_addr_r  <= '0;
      s1_valid_r  <= 1'b0;
      map_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (!init_done_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(NUM_VERTICES - 1)) begin
          init_done_r <= 1'b1;
        end
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      map_r <= map_nxt;
      if (s1_fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.colored_vertex = out_vtx_r;
  assign out_ch.chosen_color   = out_color_r;
  assign out_ch.color_found    = out_found_r;

`ifndef SYNTH
  a_map_clear_after_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fin |=> (map_r == '0))
    else $error("used map not cleared after final beat");

  a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_last_r))
    else $error("result without final beat");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !init_done_r |-> !accept)
    else $error("beat accepted during clearing pass");

  a_color_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> (32'(out_color_r) < NUM_COLORS))
    else $error("chosen color out of range");

  a_result_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !s1_fin)
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

@@ tb/tb_greedy_first_fit_vertex_coloring.sv @@
`timescale 1ns / 1ps

module tb_greedy_first_fit_vertex_coloring;

  localparam int unsigned NUM_VERTICES  = 1024;
  localparam int unsigned NUM_COLORS    = 256;
  localparam int unsigned PALETTE_BASE  = 512;
  localparam int unsigned LADDER_COLORS = 40;

  typedef struct packed {
    gffc_pkg::idx_t   vertex;
    gffc_pkg::color_t color;
    logic             found;
  } coloring_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  gffc_in_if  in_ch ();
  gffc_out_if out_ch ();

  greedy_first_fit_vertex_coloring i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  gffc_pkg::store_entry_t color_table [NUM_VERTICES];
  logic [NUM_COLORS-1:0]  taken_colors = '0;
  coloring_t              pending_colorings[$];
  int unsigned            fail_count = 0;
  bit                     idle_en = 1'b1;
  int unsigned            stall_left = 0;

  task automatic predict_coloring(gffc_pkg::idx_t v, gffc_pkg::idx_t n, logic has,
                                  logic last);
    coloring_t              r;
    int                     c;
    gffc_pkg::store_entry_t e;
    if (has && color_table[n].colored) begin
      taken_colors[color_table[n].color] = 1'b1;
    end
    if (last) begin
      r.vertex = v;
      r.found  = 1'b0;
      r.color  = '0;
      for (c = 0; c < NUM_COLORS; c++) begin
        if (!r.found && !taken_colors[c]) begin
          r.found = 1'b1;
          r.color = gffc_pkg::color_t'(c);
        end
      end
      taken_colors = '0;
      e = gffc_pkg::UNCOLORED;
      if (r.found) begin
        e.colored = 1'b1;
        e.color   = r.color;
      end
      color_table[v] = e;
      pending_colorings.push_back(r);
    end
  endtask

  // results are checked before the same edge's input beat is predicted
  always @(posedge clk) begin : scoreboard
    coloring_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_colorings.size() == 0) begin
          $error("unexpected result beat: vertex %0d color %0d found %0b",
                 out_ch.colored_vertex, out_ch.chosen_color, out_ch.color_found);
          fail_count++;
        end else begin
          want = pending_colorings.pop_front();
          if (out_ch.colored_vertex !== want.vertex) begin
            $error("colored_vertex: expected %0d, actual %0d", want.vertex,
                   out_ch.colored_vertex);
            fail_count++;
          end
          if (out_ch.chosen_color !== want.color) begin
            $error("chosen_color: expected %0d, actual %0d", want.color,
                   out_ch.chosen_color);
            fail_count++;
          end
          if (out_ch.color_found !== want.found) begin
            $error("color_found: expected %0b, actual %0b", want.found,
                   out_ch.color_found);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_coloring(in_ch.vertex_index, in_ch.neighbor_index, in_ch.has_neighbor,
                         in_ch.last_neighbor);
      end
    end
  end

  // result side backpressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // called at a falling edge, returns at a falling edge with valid left high
  task automatic send_item(gffc_pkg::idx_t v, gffc_pkg::idx_t n, logic has, logic last);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.vertex_index   <= v;
    in_ch.neighbor_index <= n;
    in_ch.has_neighbor   <= has;
    in_ch.last_neighbor  <= last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic test_isolated_vertices();
    send_item(gffc_pkg::idx_t'(0), gffc_pkg::idx_t'(1023), 1'b0, 1'b1);
    send_item(gffc_pkg::idx_t'(1023), gffc_pkg::idx_t'(0), 1'b0, 1'b1);
    // colored neighbor, then a closing beat without a neighbor
    send_item(gffc_pkg::idx_t'(1), gffc_pkg::idx_t'(0), 1'b1, 1'b0);
    send_item(gffc_pkg::idx_t'(1), gffc_pkg::idx_t'(1023), 1'b0, 1'b1);
  endtask

  task automatic test_neighbor_colors();
    send_item(gffc_pkg::idx_t'(2), gffc_pkg::idx_t'(0), 1'b1, 1'b0);
    send_item(gffc_pkg::idx_t'(2), gffc_pkg::idx_t'(1), 1'b1, 1'b1);
    send_item(gffc_pkg::idx_t'(3), gffc_pkg::idx_t'(1), 1'b1, 1'b1);
    // uncolored neighbor adds nothing
    send_item(gffc_pkg::idx_t'(4), gffc_pkg::idx_t'(999), 1'b1, 1'b0);
    send_item(gffc_pkg::idx_t'(4), gffc_pkg::idx_t'(3), 1'b1, 1'b1);
    // self neighbor, then the same vertex again
    send_item(gffc_pkg::idx_t'(2), gffc_pkg::idx_t'(2), 1'b1, 1'b1);
    send_item(gffc_pkg::idx_t'(2), gffc_pkg::idx_t'(0), 1'b1, 1'b0);
    send_item(gffc_pkg::idx_t'(2), gffc_pkg::idx_t'(2), 1'b1, 1'b1);
  endtask

  // clique that climbs the palette one color per vertex, then vertices reusing it
  task automatic test_color_ladder();
    int k;
    int j;
    send_item(gffc_pkg::idx_t'(PALETTE_BASE), gffc_pkg::idx_t'(0), 1'b0, 1'b1);
    for (k = 1; k <= LADDER_COLORS; k++) begin
      for (j = 0; j < k; j++) begin
        send_item(gffc_pkg::idx_t'(PALETTE_BASE + k), gffc_pkg::idx_t'(PALETTE_BASE + j),
                  1'b1, j == k - 1);
      end
    end
    send_item(gffc_pkg::idx_t'(PALETTE_BASE + LADDER_COLORS + 1),
              gffc_pkg::idx_t'(PALETTE_BASE + LADDER_COLORS), 1'b1, 1'b0);
    send_item(gffc_pkg::idx_t'(PALETTE_BASE + LADDER_COLORS + 1),
              gffc_pkg::idx_t'(PALETTE_BASE), 1'b1, 1'b1);
    send_item(gffc_pkg::idx_t'(PALETTE_BASE),
              gffc_pkg::idx_t'(PALETTE_BASE + LADDER_COLORS), 1'b1, 1'b1);
  endtask

  task automatic test_random_graph();
    int unsigned    sent;
    int             deg;
    int             k;
    gffc_pkg::idx_t base;
    gffc_pkg::idx_t v;
    gffc_pkg::idx_t n;
    logic           has;
    sent = 0;
    base = '0;
    while (sent < 950) begin
      if ($urandom_range(0, 19) == 0) idle_en = !idle_en;
      if ($urandom_range(0, 31) == 0) begin
        base = gffc_pkg::idx_t'($urandom_range(0, NUM_VERTICES - 64));
      end
      v = ($urandom_range(0, 7) == 0) ? gffc_pkg::idx_t'($urandom) :
                                        gffc_pkg::idx_t'(base + $urandom_range(0, 63));
      deg = $urandom_range(0, 10);
      for (k = 0; k < deg; k++) begin
        n = ($urandom_range(0, 9) == 0) ? gffc_pkg::idx_t'($urandom) :
                                          gffc_pkg::idx_t'(base + $urandom_range(0, 63));
        if ($urandom_range(0, 19) == 0) begin
          // broken run: stray vertex index, neighbor flag at random
          has = 1'($urandom_range(0, 1));
          send_item(gffc_pkg::idx_t'($urandom), n, has, 1'b0);
          if (has) sent++;
        end else begin
          send_item(v, n, 1'b1, 1'b0);
          sent++;
        end
      end
      n = ($urandom_range(0, 3) == 0) ? gffc_pkg::idx_t'($urandom) :
                                        gffc_pkg::idx_t'(base + $urandom_range(0, 63));
      has = (deg == 0) ? ($urandom_range(0, 3) == 0) : 1'($urandom_range(0, 1));
      send_item(v, n, has, 1'b1);
      sent++;
    end
  endtask

  // no idling: beats back to back; in two of three cases a vertex's first beat reads the one just written
  task automatic test_back_to_back();
    int             k;
    gffc_pkg::idx_t prev;
    gffc_pkg::idx_t v;
    idle_en = 1'b0;
    prev = gffc_pkg::idx_t'($urandom);
    send_item(prev, gffc_pkg::idx_t'(0), 1'b0, 1'b1);
    for (k = 0; k < 150; k++) begin
      v = ($urandom_range(0, 3) == 0) ? prev : gffc_pkg::idx_t'($urandom);
      case ($urandom_range(0, 2))
        0: begin
          send_item(v, prev, 1'b1, 1'b1);
        end
        1: begin
          send_item(v, prev, 1'b1, 1'b0);
          send_item(v, gffc_pkg::idx_t'($urandom), 1'b1, 1'b1);
        end
        default: begin
          send_item(v, gffc_pkg::idx_t'($urandom), 1'b0, 1'b1);
        end
      endcase
      prev = v;
    end
  endtask

  initial begin
    foreach (color_table[i]) color_table[i] = gffc_pkg::UNCOLORED;
    in_ch.valid          = 1'b0;
    in_ch.vertex_index   = '0;
    in_ch.neighbor_index = '0;
    in_ch.has_neighbor   = 1'b0;
    in_ch.last_neighbor  = 1'b0;
    out_ch.ready         = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_isolated_vertices();
    test_neighbor_colors();
    test_color_ladder();
    test_random_graph();
    test_back_to_back();

    in_ch.valid <= 1'b0;
    while (pending_colorings.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_colorings.size() == 0) begin
      $display("greedy_first_fit_vertex_coloring test passed");
    end else begin
      $display("greedy_first_fit_vertex_coloring test failed");
    end
    $finish;
  end

  initial begin
    #(64'd50_000_000);
    $display("greedy_first_fit_vertex_coloring test failed");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/gffc_pkg.sv
hw/rtl/gffc_if.sv
hw/rtl/greedy_first_fit_vertex_coloring.sv
tb/tb_greedy_first_fit_vertex_coloring.sv
